// ----- design/pst_pkg.sv -----
// shared widths, register indexes, mode codes and reset values
// command and status types between the controller and the datapath
// no dependencies
`timescale 1ns / 1ps

package pst_pkg;

	localparam int MAX_POINTS_DEF = 64;

	localparam int COORD_W   = 24;
	localparam int FACT_W    = 16;
	localparam int FRAC_BITS = 14;
	localparam int MODE_W    = 3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;

	localparam logic [MODE_W-1:0] MODE_TRANSLATE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ORIGIN     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SCALE_BOTH = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SCALE_X    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SCALE_Y    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ROTATE     = 3'd5;

	localparam logic signed [FACT_W-1:0] FACT_ONE = 16'sd16384;

	typedef struct packed {
		logic accept;
		logic div_start;
		logic diff;
		logic mul1;
		logic mul2;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic idx_last;
		logic out_free;
	} status_t;

endpackage

// ----- design/pst_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pst_ram #(
	parameter int WIDTH  = 48,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/pst_div.sv -----
// two-lane restoring divider, one quotient bit per cycle, shared divisor
// signed dividend, unsigned divisor, quotient truncated toward zero
// depends on pst_pkg
`timescale 1ns / 1ps

module pst_div #(
	parameter int SUM_W = 31,
	parameter int CNT_W = 7
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [SUM_W-1:0]          num_x,
	input  logic signed [SUM_W-1:0]          num_y,
	input  logic [CNT_W-1:0]                 den,
	output logic                             done,
	output logic signed [pst_pkg::COORD_W-1:0] quo_x,
	output logic signed [pst_pkg::COORD_W-1:0] quo_y
);

	localparam int STEP_W = $clog2(SUM_W + 1);
	localparam int W      = CNT_W + SUM_W;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  den_q;
	logic [SUM_W-1:0]  nx_q, ny_q;
	logic [CNT_W-1:0]  rx_q, ry_q;
	logic              negx_q, negy_q;
	logic [W-1:0]      nxt_x, nxt_y;
	logic [pst_pkg::COORD_W-1:0] lowx, lowy;

	function automatic logic [W-1:0] div_step(input logic [CNT_W-1:0] r,
			input logic [SUM_W-1:0] q, input logic [CNT_W-1:0] d);
		logic [CNT_W:0] t;
		t = {r, q[SUM_W-1]};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
			return {t[CNT_W-1:0], q[SUM_W-2:0], 1'b1};
		end
		return {t[CNT_W-1:0], q[SUM_W-2:0], 1'b0};
	endfunction

	assign nxt_x = div_step(rx_q, nx_q, den_q);
	assign nxt_y = div_step(ry_q, ny_q, den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			negx_q <= num_x[SUM_W-1];
			negy_q <= num_y[SUM_W-1];
			nx_q   <= num_x[SUM_W-1] ? SUM_W'(-num_x) : SUM_W'(num_x);
			ny_q   <= num_y[SUM_W-1] ? SUM_W'(-num_y) : SUM_W'(num_y);
			rx_q   <= '0;
			ry_q   <= '0;
		end else if (busy_q) begin
			{rx_q, nx_q} <= nxt_x;
			{ry_q, ny_q} <= nxt_y;
		end
	end

	// magnitude never exceeds the coordinate range, so low bits suffice
	assign lowx  = nx_q[pst_pkg::COORD_W-1:0];
	assign lowy  = ny_q[pst_pkg::COORD_W-1:0];
	assign quo_x = negx_q ? -lowx : lowx;
	assign quo_y = negy_q ? -lowy : lowy;
	assign done  = done_q;

endmodule

// ----- design/pst_dp.sv -----
// datapath: config registers, point store, sums, centroid divider,
// per-axis multiplier lanes and the output register
// depends on pst_pkg, pst_ram, pst_div
`timescale 1ns / 1ps

module pst_dp #(
	parameter int MAX_POINTS = pst_pkg::MAX_POINTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pst_pkg::cmd_t                        cmd,
	output pst_pkg::status_t                     status,
	input  logic signed [pst_pkg::COORD_W-1:0]   point_x,
	input  logic signed [pst_pkg::COORD_W-1:0]   point_y,
	input  logic                                 cfg_we,
	input  logic [pst_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pst_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic signed [pst_pkg::COORD_W-1:0]   out_x,
	output logic signed [pst_pkg::COORD_W-1:0]   out_y,
	output logic                                 out_last
);

	localparam int CW     = pst_pkg::COORD_W;
	localparam int FW     = pst_pkg::FACT_W;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SUM_W  = CW + CNT_W;
	localparam int DIFF_W = CW + 1;
	localparam int PROD_W = DIFF_W + FW;
	localparam int ACC_W  = PROD_W + 1;
	localparam int RES_W  = ACC_W - pst_pkg::FRAC_BITS + 1;

	// config registers
	logic [pst_pkg::MODE_W-1:0] mode_q;
	logic signed [FW-1:0]       scale_q, cos_q, sin_q;
	logic signed [CW-1:0]       shx_q, shy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= pst_pkg::MODE_TRANSLATE;
			scale_q <= pst_pkg::FACT_ONE;
			cos_q   <= pst_pkg::FACT_ONE;
			sin_q   <= '0;
			shx_q   <= '0;
			shy_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pst_pkg::REG_MODE:    mode_q  <= cfg_data[pst_pkg::MODE_W-1:0];
				pst_pkg::REG_SCALE:   scale_q <= cfg_data[FW-1:0];
				pst_pkg::REG_COS:     cos_q   <= cfg_data[FW-1:0];
				pst_pkg::REG_SIN:     sin_q   <= cfg_data[FW-1:0];
				pst_pkg::REG_SHIFT_X: shx_q   <= cfg_data[CW-1:0];
				pst_pkg::REG_SHIFT_Y: shy_q   <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// set accumulation
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic [CNT_W-1:0]        count_q, idx_q;
	logic signed [CW-1:0]    center_x_q, center_y_q;
	logic                    count_full;
	logic                    idx_last;
	logic                    div_done;
	logic signed [CW-1:0]    quo_x, quo_y;
	logic [2*CW-1:0]         rd_data;

	assign count_full = (count_q == CNT_W'(MAX_POINTS));
	assign idx_last   = (idx_q == count_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q    <= '0;
			sum_y_q    <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			center_x_q <= '0;
			center_y_q <= '0;
		end else begin
			if (cmd.accept && !count_full) begin
				sum_x_q <= sum_x_q + SUM_W'(point_x);
				sum_y_q <= sum_y_q + SUM_W'(point_y);
				count_q <= count_q + CNT_W'(1);
			end
			if (div_done) begin
				center_x_q <= quo_x;
				center_y_q <= quo_y;
			end
			if (cmd.emit) begin
				if (idx_last) begin
					idx_q   <= '0;
					count_q <= '0;
					sum_x_q <= '0;
					sum_y_q <= '0;
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
		end
	end

	pst_ram #(
		.WIDTH (2 * CW),
		.DEPTH (MAX_POINTS),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk  (clk),
		.we   (cmd.accept && !count_full),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata({point_x, point_y}),
		.raddr(idx_q[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	pst_div #(
		.SUM_W(SUM_W),
		.CNT_W(CNT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num_x (sum_x_q),
		.num_y (sum_y_q),
		.den   (count_q),
		.done  (div_done),
		.quo_x (quo_x),
		.quo_y (quo_y)
	);

	// offsets from the centroid
	logic signed [CW-1:0]     x_q, y_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			x_q  <= rd_data[2*CW-1:CW];
			y_q  <= rd_data[CW-1:0];
			dx_q <= DIFF_W'($signed(rd_data[2*CW-1:CW])) - DIFF_W'(center_x_q);
			dy_q <= DIFF_W'($signed(rd_data[CW-1:0])) - DIFF_W'(center_y_q);
		end
	end

	// one multiplier per axis, used twice: own offset, then cross term
	logic                     rot;
	logic signed [FW-1:0]     k1;
	logic signed [DIFF_W-1:0] ma_x, ma_y;
	logic signed [FW-1:0]     mb;
	logic signed [PROD_W-1:0] prod_x, prod_y;
	logic signed [PROD_W-1:0] p1x_q, p1y_q, p2x_q, p2y_q;

	assign rot    = (mode_q == pst_pkg::MODE_ROTATE);
	assign k1     = rot ? cos_q : scale_q;
	assign ma_x   = cmd.mul2 ? dy_q : dx_q;
	assign ma_y   = cmd.mul2 ? dx_q : dy_q;
	assign mb     = cmd.mul2 ? sin_q : k1;
	assign prod_x = ma_x * mb;
	assign prod_y = ma_y * mb;

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			p1x_q <= prod_x;
			p1y_q <= prod_y;
		end
		if (cmd.mul2) begin
			p2x_q <= prod_x;
			p2y_q <= prod_y;
		end
	end

	// combine, shift, re-center and saturate
	logic signed [ACC_W-1:0] acc_x, acc_y, sh_x, sh_y;
	logic signed [RES_W-1:0] mx, my, cand_x, cand_y;

	function automatic logic signed [CW-1:0] sat_coord(input logic signed [RES_W-1:0] v);
		if ((&v[RES_W-1:CW-1]) || !(|v[RES_W-1:CW-1])) begin
			return v[CW-1:0];
		end
		return v[RES_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	endfunction

	assign acc_x = rot ? (ACC_W'(p1x_q) - ACC_W'(p2x_q)) : ACC_W'(p1x_q);
	assign acc_y = rot ? (ACC_W'(p1y_q) + ACC_W'(p2y_q)) : ACC_W'(p1y_q);
	assign sh_x  = acc_x >>> pst_pkg::FRAC_BITS;
	assign sh_y  = acc_y >>> pst_pkg::FRAC_BITS;
	assign mx    = RES_W'(sh_x) + RES_W'(center_x_q);
	assign my    = RES_W'(sh_y) + RES_W'(center_y_q);

	always_comb begin
		cand_x = RES_W'(x_q);
		cand_y = RES_W'(y_q);
		unique case (mode_q)
			pst_pkg::MODE_TRANSLATE: begin
				cand_x = RES_W'(x_q) + RES_W'(shx_q);
				cand_y = RES_W'(y_q) + RES_W'(shy_q);
			end
			pst_pkg::MODE_ORIGIN: begin
				cand_x = RES_W'(dx_q);
				cand_y = RES_W'(dy_q);
			end
			pst_pkg::MODE_SCALE_BOTH, pst_pkg::MODE_ROTATE: begin
				cand_x = mx;
				cand_y = my;
			end
			pst_pkg::MODE_SCALE_X: cand_x = mx;
			pst_pkg::MODE_SCALE_Y: cand_y = my;
			default: ;
		endcase
	end

	// output register
	logic                 out_valid_q;
	logic signed [CW-1:0] out_x_q, out_y_q;
	logic                 out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_x_q    <= sat_coord(cand_x);
			out_y_q    <= sat_coord(cand_y);
			out_last_q <= idx_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_last  = out_last_q;

	assign status.div_done = div_done;
	assign status.idx_last = idx_last;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

// ----- design/pst_ctrl.sv -----
// controller: load, centroid divide, then a per-point emit sequence
// depends on pst_pkg
`timescale 1ns / 1ps

module pst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_point,
	input  pst_pkg::status_t status,
	output logic             in_stall,
	output pst_pkg::cmd_t    cmd
);

	typedef enum logic [7:0] {
		ST_LOAD   = 8'b0000_0001,
		ST_DSTART = 8'b0000_0010,
		ST_DWAIT  = 8'b0000_0100,
		ST_READ   = 8'b0000_1000,
		ST_DIFF   = 8'b0001_0000,
		ST_MUL1   = 8'b0010_0000,
		ST_MUL2   = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_stall      = 1'b1;
		unique case (state_q)
			ST_LOAD: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && last_point) begin
					state_d = ST_DSTART;
				end
			end
			ST_DSTART: begin
				// sums now include the closing point
				cmd.div_start = 1'b1;
				state_d       = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (status.div_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_DIFF;
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = status.idx_last ? ST_LOAD : ST_READ;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

endmodule

// ----- design/point_set_centroid_transform.sv -----
// channel  | handshake            | payload
// in       | in_valid / in_stall  | point_x, point_y, last_point
// out      | out_valid / out_stall| out_x, out_y, out_last
// cfg      | cfg_we               | cfg_index, cfg_data
//
// points load one per cycle while in_stall is low. after the closing point, the centroid
// divider works one quotient bit a cycle. each point then passes through store read,
// offset, two multiplier passes per axis lane, and the output register load.
// a stalled output holds the emit sequence at its last step; in_stall is high
// from the closing point until the last result is in the output register.
// reset clears control and config; the point store needs no clearing.
// top level: controller plus datapath; depends on pst_pkg, pst_ctrl, pst_dp
`timescale 1ns / 1ps

module point_set_centroid_transform #(
	parameter int MAX_POINTS = pst_pkg::MAX_POINTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [pst_pkg::COORD_W-1:0]   point_x,
	input  logic signed [pst_pkg::COORD_W-1:0]   point_y,
	input  logic                                 last_point,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pst_pkg::COORD_W-1:0]   out_x,
	output logic signed [pst_pkg::COORD_W-1:0]   out_y,
	output logic                                 out_last,
	input  logic                                 cfg_we,
	input  logic [pst_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pst_pkg::CFG_DATA_W-1:0]       cfg_data
);

	pst_pkg::cmd_t    cmd;
	pst_pkg::status_t status;

	pst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_point(last_point),
		.status    (status),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	pst_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.point_x  (point_x),
		.point_y  (point_y),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_last (out_last)
	);

endmodule

// ----- design/pst_checker.sv -----
// port-level checks on the transform block, bound to the top level
// depends on pst_pkg and point_set_centroid_transform
`timescale 1ns / 1ps

module pst_port_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               last_point,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [pst_pkg::COORD_W-1:0] out_x,
	input logic signed [pst_pkg::COORD_W-1:0] out_y,
	input logic                               out_last
);

	// closing request starts the divide, so input stays blocked for a while
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_point) |=> in_stall ##1 in_stall)
		else $error("input taken right after closing request");

	// loading and emitting never overlap
	a_no_emit_while_loading: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result appeared while loading points");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_last)))
		else $error("stalled result changed");

endmodule

bind point_set_centroid_transform pst_port_checker u_pst_port_checker (.*);

// ----- dv/pst_checker.sv -----
// checker for point_set_centroid_transform: follows the register writes, the point requests and
// the output channel, predicts every transformed point and compares it field by field
// depends on pst_pkg
`timescale 1ns / 1ps

module pst_checker #(
	parameter int MAX_POINTS = pst_pkg::MAX_POINTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [pst_pkg::COORD_W-1:0]   point_x,
	input  logic signed [pst_pkg::COORD_W-1:0]   point_y,
	input  logic                                 last_point,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [pst_pkg::COORD_W-1:0]   out_x,
	input  logic signed [pst_pkg::COORD_W-1:0]   out_y,
	input  logic                                 out_last,
	input  logic                                 cfg_we,
	input  logic [pst_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pst_pkg::CFG_DATA_W-1:0]       cfg_data,
	output int                                   fail_count,
	output int                                   outstanding
);

	import pst_pkg::*;

	localparam longint CRD_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
	localparam longint CRD_LO = -(longint'(1) <<< (COORD_W - 1));

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      last;
	} xy_point_t;

	// set being loaded
	logic signed [COORD_W-1:0] held_x [MAX_POINTS];
	logic signed [COORD_W-1:0] held_y [MAX_POINTS];
	longint                    acc_x;
	longint                    acc_y;
	int                        held_cnt;
	logic signed [COORD_W-1:0] cent_x;
	logic signed [COORD_W-1:0] cent_y;

	// register copies
	logic [MODE_W-1:0]         cur_mode;
	logic signed [FACT_W-1:0]  k_scale;
	logic signed [FACT_W-1:0]  k_cos;
	logic signed [FACT_W-1:0]  k_sin;
	logic signed [COORD_W-1:0] sh_x;
	logic signed [COORD_W-1:0] sh_y;

	xy_point_t transformed_q [$];
	xy_point_t want;
	int        n_fail;

	function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
		if (v > CRD_HI)
			return CRD_HI[COORD_W-1:0];
		if (v < CRD_LO)
			return CRD_LO[COORD_W-1:0];
		return COORD_W'(v);
	endfunction

	// products are floored by the arithmetic shift
	function automatic longint scaled_about(input longint p, input longint c, input longint k);
		return (((p - c) * k) >>> FRAC_BITS) + c;
	endfunction

	function automatic xy_point_t move_point(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py, input logic is_last);
		xy_point_t r;
		longint    x, y, cx, cy, dx, dy, ks, kc, kn;
		x  = px;
		y  = py;
		cx = cent_x;
		cy = cent_y;
		dx = x - cx;
		dy = y - cy;
		ks = k_scale;
		kc = k_cos;
		kn = k_sin;
		r.x = px;
		r.y = py;
		r.last = is_last;
		unique case (cur_mode)
			MODE_TRANSLATE: begin
				r.x = clamp_coord(x + longint'(sh_x));
				r.y = clamp_coord(y + longint'(sh_y));
			end
			MODE_ORIGIN: begin
				r.x = clamp_coord(dx);
				r.y = clamp_coord(dy);
			end
			MODE_SCALE_BOTH: begin
				r.x = clamp_coord(scaled_about(x, cx, ks));
				r.y = clamp_coord(scaled_about(y, cy, ks));
			end
			MODE_SCALE_X: r.x = clamp_coord(scaled_about(x, cx, ks));
			MODE_SCALE_Y: r.y = clamp_coord(scaled_about(y, cy, ks));
			MODE_ROTATE: begin
				r.x = clamp_coord(((dx * kc - dy * kn) >>> FRAC_BITS) + cx);
				r.y = clamp_coord(((dy * kc + dx * kn) >>> FRAC_BITS) + cy);
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x = 0;
			acc_y = 0;
			held_cnt = 0;
			cent_x = '0;
			cent_y = '0;
			cur_mode = MODE_TRANSLATE;
			k_scale = FACT_ONE;
			k_cos = FACT_ONE;
			k_sin = '0;
			sh_x = '0;
			sh_y = '0;
			transformed_q.delete();
			n_fail = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (transformed_q.size() == 0) begin
					$error("unexpected output point: out_x %0d out_y %0d out_last %0d",
						out_x, out_y, out_last);
					n_fail++;
				end else begin
					want = transformed_q.pop_front();
					if (out_x !== want.x) begin
						$error("out_x expected %0d got %0d", want.x, out_x);
						n_fail++;
					end
					if (out_y !== want.y) begin
						$error("out_y expected %0d got %0d", want.y, out_y);
						n_fail++;
					end
					if (out_last !== want.last) begin
						$error("out_last expected %0d got %0d", want.last, out_last);
						n_fail++;
					end
				end
			end

			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE:    cur_mode = cfg_data[MODE_W-1:0];
					REG_SCALE:   k_scale = cfg_data[FACT_W-1:0];
					REG_COS:     k_cos = cfg_data[FACT_W-1:0];
					REG_SIN:     k_sin = cfg_data[FACT_W-1:0];
					REG_SHIFT_X: sh_x = cfg_data[COORD_W-1:0];
					REG_SHIFT_Y: sh_y = cfg_data[COORD_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				// a full store drops the point but still honors the closing mark
				if (held_cnt < MAX_POINTS) begin
					held_x[held_cnt] = point_x;
					held_y[held_cnt] = point_y;
					acc_x += longint'(point_x);
					acc_y += longint'(point_y);
					held_cnt++;
				end
				if (last_point) begin
					cent_x = COORD_W'(acc_x / longint'(held_cnt));
					cent_y = COORD_W'(acc_y / longint'(held_cnt));
					for (int i = 0; i < held_cnt; i++)
						transformed_q = {transformed_q, move_point(held_x[i], held_y[i],
							i == held_cnt - 1)};
					acc_x = 0;
					acc_y = 0;
					held_cnt = 0;
				end
			end

			fail_count <= n_fail;
			outstanding <= transformed_q.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// top of the point_set_centroid_transform testbench: clock, reset, register writes and point
// sets, directed then random; pst_checker does the prediction and comparison
// depends on pst_pkg, pst_checker and the block itself
`timescale 1ns / 1ps

module tb_top;

	import pst_pkg::*;

	localparam int MAX_POINTS    = MAX_POINTS_DEF;
	localparam int RAND_ITEMS    = 450;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES    = 50;
	localparam int CYCLE_LIMIT   = 400000;

	// mode values with no transform and register indexes beyond the list
	localparam logic [MODE_W-1:0]    MODE_SPARE_A = 3'd6;
	localparam logic [MODE_W-1:0]    MODE_SPARE_B = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B  = 3'd7;

	localparam logic signed [COORD_W-1:0] CRD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] CRD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [FACT_W-1:0]  FACT_MAX = {1'b0, {(FACT_W-1){1'b1}}};
	localparam logic signed [FACT_W-1:0]  FACT_MIN = {1'b1, {(FACT_W-1){1'b0}}};
	localparam logic signed [FACT_W-1:0]  FACT_FLIP = -FACT_ONE;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic                      last_point = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic                      out_last;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;

	int   fail_count;
	int   outstanding;
	int   cycle_cnt = 0;
	logic idle_on = 1'b1;

	point_set_centroid_transform #(.MAX_POINTS(MAX_POINTS)) DUT (.*);

	pst_checker #(.MAX_POINTS(MAX_POINTS)) u_checker (.*);

	always #5 clk = ~clk;

	always @(posedge clk)
		out_stall <= idle_on && ($urandom_range(99) < 37);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic signed [COORD_W-1:0] pick_coord();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return CRD_MAX;
		if (r < 16)
			return CRD_MIN;
		if (r < 22)
			return '0;
		if (r < 55)
			return COORD_W'(int'($urandom_range(8191)) - 4096);
		return COORD_W'($urandom);
	endfunction

	function automatic logic signed [FACT_W-1:0] pick_factor();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return FACT_MIN;
		if (r < 24)
			return FACT_MAX;
		if (r < 34)
			return FACT_ONE;
		if (r < 44)
			return FACT_FLIP;
		if (r < 48)
			return '0;
		return FACT_W'($urandom);
	endfunction

	// mostly small sets, a few near the store size and a few that overflow it
	function automatic int pick_set_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 90)
			return $urandom_range(9, 40);
		if (r < 96)
			return $urandom_range(41, MAX_POINTS);
		return $urandom_range(MAX_POINTS + 1, MAX_POINTS + 6);
	endfunction

	task automatic send_point(input logic signed [COORD_W-1:0] px,
			input logic signed [COORD_W-1:0] py, input logic is_last);
		while (idle_on && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		last_point <= is_last;
		do @(posedge clk); while (in_stall);
	endtask

	// the sender holds off until every predicted point has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// upper data bits beyond a register's width are random junk
	task automatic reprogram();
		logic [MODE_W-1:0]     m;
		logic [CFG_DATA_W-1:0] d;
		if ($urandom_range(9) == 0)
			m = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
		else
			m = MODE_W'($urandom_range(MODE_TRANSLATE, MODE_ROTATE));
		d = CFG_DATA_W'($urandom);
		d[MODE_W-1:0] = m;
		write_reg(REG_MODE, d);
		d = CFG_DATA_W'($urandom);
		d[FACT_W-1:0] = pick_factor();
		write_reg(REG_SCALE, d);
		d = CFG_DATA_W'($urandom);
		d[FACT_W-1:0] = pick_factor();
		write_reg(REG_COS, d);
		d = CFG_DATA_W'($urandom);
		d[FACT_W-1:0] = pick_factor();
		write_reg(REG_SIN, d);
		write_reg(REG_SHIFT_X, pick_coord());
		write_reg(REG_SHIFT_Y, pick_coord());
		if ($urandom_range(7) == 0)
			write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
	endtask

	initial begin
		int sent;
		int set_no;
		int size;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: translate by zero
		send_point(CRD_MAX, CRD_MIN, 1'b1);

		// translate with saturation both ways
		wait_drained();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_TRANSLATE));
		write_reg(REG_SHIFT_X, CRD_MAX);
		write_reg(REG_SHIFT_Y, CRD_MIN);
		send_point(CRD_MAX, CRD_MIN, 1'b0);
		send_point(CRD_MIN, CRD_MAX, 1'b0);
		send_point('0, '0, 1'b1);

		// centroid to origin, negative sum truncated toward zero
		wait_drained();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_ORIGIN));
		send_point(CRD_MAX, CRD_MIN, 1'b0);
		send_point(CRD_MIN, CRD_MIN, 1'b0);
		send_point(CRD_MIN, CRD_MIN, 1'b1);

		wait_drained();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_SCALE_BOTH));
		write_reg(REG_SCALE, CFG_DATA_W'(FACT_MIN));
		send_point(CRD_MAX, CRD_MIN, 1'b0);
		send_point(CRD_MIN, CRD_MAX, 1'b1);

		wait_drained();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_SCALE_X));
		write_reg(REG_SCALE, CFG_DATA_W'(FACT_MAX));
		send_point(-24'sd1, 24'sd1, 1'b0);
		send_point(CRD_MAX, -24'sd3, 1'b0);
		send_point(24'sd256, -24'sd256, 1'b1);

		// flip about the centroid
		wait_drained();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_SCALE_Y));
		write_reg(REG_SCALE, CFG_DATA_W'(FACT_FLIP));
		send_point(24'sd100, -24'sd100, 1'b0);
		send_point(CRD_MIN, CRD_MAX, 1'b0);
		send_point(24'sd7, CRD_MIN, 1'b1);

		wait_drained();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_ROTATE));
		write_reg(REG_COS, CFG_DATA_W'(FACT_MIN));
		write_reg(REG_SIN, CFG_DATA_W'(FACT_MAX));
		send_point(CRD_MAX, CRD_MIN, 1'b0);
		send_point(CRD_MIN, CRD_MAX, 1'b0);
		send_point(24'sd1, -24'sd1, 1'b1);

		// modes with no transform, writes to indexes past the list
		wait_drained();
		write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
		write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE_A));
		send_point(CRD_MAX, CRD_MAX, 1'b0);
		send_point(-24'sd5, 24'sd5, 1'b1);

		wait_drained();
		write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
		write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE_B));
		send_point(CRD_MIN, '0, 1'b1);

		sent = 0;
		set_no = 0;
		while (sent < RAND_ITEMS) begin
			// one long run of sets with neither side idling
			idle_on <= !(set_no >= 12 && set_no < 20);
			if (set_no == 0 || $urandom_range(1) == 0) begin
				wait_drained();
				reprogram();
			end
			size = pick_set_size();
			for (int i = 0; i < size; i++)
				send_point(pick_coord(), pick_coord(), i == size - 1);
			sent += size;
			set_no++;
		end

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- point_set_centroid_transform.f -----
design/pst_pkg.sv
design/pst_ram.sv
design/pst_div.sv
design/pst_dp.sv
design/pst_ctrl.sv
design/point_set_centroid_transform.sv
design/pst_checker.sv
dv/pst_checker.sv
dv/tb_top.sv
